// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define RPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define RPF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/rpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpf_pkg
// Types, constants and helper functions of the palette fade sequencer.
// ----------------------------------------------------------------------------
package rpf_pkg;

  localparam int PALETTE_SIZE = 6;
  localparam int POS_W        = (PALETTE_SIZE > 2) ? $clog2(PALETTE_SIZE) : 1;

  // Reciprocal constants for the fixed divides
  localparam logic [26:0] AQ_RECIP   = 27'd122713352;  // ceil(2^32 / 35)
  localparam logic [25:0] FT_RECIP   = 26'd38498307;   // ceil(2^40 / 28560)
  localparam logic [7:0]  DIV5_RECIP = 8'd205;         // 205 / 1024 ~ 1/5

  typedef logic [2:0][7:0] rgb_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_CR_SQ,
    ST_CR_CU,
    ST_CR_CMP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CFG_THROUGH_BLACK,
    CFG_BRIGHTNESS,
    CFG_FADE_SPEED,
    CFG_START_COLOR
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LVL_ZERO,
    LVL_235,
    LVL_255
  } lvl_t;

  typedef struct packed {
    logic start;
    logic iter;
    logic cr_sq;
    logic cr_cu;
    logic cr_cmp;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
    logic need_root;
    logic bit_last;
    logic cfg_busy;
  } sts_t;

  typedef struct packed {
    rgb_t       v;
    logic [7:0] md;
  } step_res_t;

  // Fold a palette position onto the six base colors
  function automatic logic [2:0] base_idx(input logic [POS_W-1:0] pos);
    logic [4:0] p;
    p = 5'(pos);
    if (p >= 5'd12) p = p - 5'd12;
    if (p >= 5'd6)  p = p - 5'd6;
    return p[2:0];
  endfunction

  // Base palette level of one channel (channel 2 is red, 0 is blue)
  function automatic lvl_t base_lvl(input logic [2:0] idx, input logic [1:0] ch);
    lvl_t l;
    l = LVL_ZERO;
    case (idx)
      3'd0: l = (ch == 2'd2) ? LVL_255 : LVL_ZERO;
      3'd1: l = (ch == 2'd2) ? LVL_235 : ((ch == 2'd1) ? LVL_255 : LVL_ZERO);
      3'd2: l = (ch == 2'd0) ? LVL_255 : LVL_ZERO;
      3'd3: l = (ch == 2'd2) ? LVL_255 : ((ch == 2'd0) ? LVL_235 : LVL_ZERO);
      3'd4: l = (ch == 2'd1) ? LVL_255 : LVL_ZERO;
      3'd5: l = (ch == 2'd1) ? LVL_235 : ((ch == 2'd0) ? LVL_255 : LVL_ZERO);
      default: l = LVL_ZERO;
    endcase
    return l;
  endfunction

  // Move each channel one count toward the target; report largest distance left, at least 15
  function automatic step_res_t step_rgb(input rgb_t v, input rgb_t t);
    step_res_t r;
    logic [7:0] d;
    r.md = 8'd15;
    r.v  = v;
    for (int c = 0; c < 3; c++) begin
      if (v[c] < t[c]) begin
        r.v[c] = v[c] + 8'd1;
      end else if (v[c] > t[c]) begin
        r.v[c] = v[c] - 8'd1;
      end
      d = (r.v[c] > t[c]) ? (r.v[c] - t[c]) : (t[c] - r.v[c]);
      if (d > r.md) r.md = d;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rgb_palette_fade_sequencer_top.sv =====
// Sequence: accept, palette iterations until one takes a step or the third
//   has run, then for a black or direct fade a bit-serial cube root search
//   over 7 bits (square, cube and compare steps per bit), then result load.
// Throughput: one transaction at a time, the next accepted once the result is
//   loaded; a register write stalls the input until the derived values settle.
// Reset: synchronous active-low rst_n; clears color, position and phase state.
// ----------------------------------------------------------------------------
// rgb_palette_fade_sequencer_top
// Frame-tick RGB palette fade engine with through-black mode and stop abort.
// ----------------------------------------------------------------------------
module rgb_palette_fade_sequencer_top import rpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_stop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_frame_delay_ms,
  output logic        out_was_interrupted,
  output logic [2:0]  out_palette_slot
);

  cmd_t cmd;
  sts_t sts;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  rpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rpf_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_stop             (in_stop),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .out_frame_delay_ms  (out_frame_delay_ms),
    .out_was_interrupted (out_was_interrupted),
    .out_palette_slot    (out_palette_slot)
  );

endmodule

// ===== rtl/core/rpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpf_ctrl
// Sequencer of the fade engine: palette iterations, cube root search and
// result hand-off.
// ----------------------------------------------------------------------------
module rpf_ctrl import rpf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.cfg_busy) state_nxt = ST_ITER;
      end
      ST_ITER: begin
        if (sts.iter_done) state_nxt = sts.need_root ? ST_CR_SQ : ST_DONE;
      end
      ST_CR_SQ:  state_nxt = ST_CR_CU;
      ST_CR_CU:  state_nxt = ST_CR_CMP;
      ST_CR_CMP: state_nxt = sts.bit_last ? ST_DONE : ST_CR_SQ;
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:   cmd.start  = in_valid && !sts.cfg_busy;
      ST_ITER:   cmd.iter   = 1'b1;
      ST_CR_SQ:  cmd.cr_sq  = 1'b1;
      ST_CR_CU:  cmd.cr_cu  = 1'b1;
      ST_CR_CMP: cmd.cr_cmp = 1'b1;
      ST_DONE:   cmd.finish = !out_valid_r || !out_stall;
      default:   cmd = '0;
    endcase
  end

  // Hold the result until the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stall while busy or while the derived constants settle after a write
  assign in_stall  = (state_r != ST_IDLE) || sts.cfg_busy;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/rpf_dp.sv =====
// ----------------------------------------------------------------------------
// rpf_dp
// Datapath of the fade engine: configuration, color state, scaled targets,
// frame time and the bit-serial cube root delay search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpf_dp import rpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_stop,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_frame_delay_ms,
  output logic        out_was_interrupted,
  output logic [2:0]  out_palette_slot
);

  // Configuration
  logic       tb_r, tb_nxt;
  logic [7:0] bright_r, bright_nxt;
  logic [7:0] speed_r, speed_nxt;
  logic [1:0] settle_r, settle_nxt;

  // Fade state
  rgb_t             cur_r, cur_nxt;
  rgb_t             res_r, res_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             bpn_r, bpn_nxt;

  // Per-transaction working registers
  logic       stop_r, stop_nxt;
  logic [1:0] it_r, it_nxt;
  logic       dyn_r, dyn_nxt;
  logic       run_res_r, run_res_nxt;
  logic [7:0] md_r, md_nxt;
  logic [6:0] n_r, n_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [13:0] p1_r;
  logic [20:0] p2_r;

  // Derived constants, refreshed every cycle from the configuration
  logic [15:0] aq_r;
  logic [7:0]  s255_r, s235_r;
  logic [22:0] ftx_r;
  logic [7:0]  f_r;
  logic [5:0]  d5_r;
  logic [15:0] f2_r;
  logic [22:0] f3_r;

  // Result registers
  logic [7:0] red_r, green_r, blue_r, delay_r;
  logic       intr_r;
  logic [2:0] slot_r;

  logic [20:0] aq_v;
  logic [47:0] aq_prod;
  logic [23:0] m255, m235;
  logic [17:0] ft_num;
  logic [48:0] ft_prod;
  logic [15:0] d5_prod;

  rgb_t             tgt;
  step_res_t        st_cur, st_blk, st_res;
  logic [POS_W-1:0] pos_adv;
  logic             step_now, dyn_now;
  logic [6:0]       cand;
  logic [28:0]      p3;

  function automatic logic [23:0] s255_mul(input logic [15:0] a);
    return 24'(a) * 24'd255;
  endfunction

  // Alpha in Q1.15 and the two scaled palette levels
  assign aq_v    = 21'({5'd0, bright_r} + 13'd25) << 12;
  assign aq_prod = 48'(aq_v) * 48'(AQ_RECIP);
  assign m255    = 24'(s255_mul(aq_r));
  assign m235    = 24'(aq_r) * 24'd235;

  // Frame time and its fifth
  assign ft_num  = 18'(9'd256 - 9'(speed_r)) * 18'd280 + 18'(8'd255 - bright_r) * 18'd255;
  assign ft_prod = 49'(ftx_r) * 49'(FT_RECIP);
  assign d5_prod = 16'(f_r) * 16'(DIV5_RECIP);

  always_ff @(posedge clk) begin
    aq_r   <= aq_prod[47:32];
    s255_r <= m255[22:15];
    s235_r <= m235[22:15];
    ftx_r  <= 23'(ft_num * 18'd37);
    f_r    <= 8'(9'd15 + 9'(ft_prod[48:40]));
    d5_r   <= d5_prod[15:10];
    f2_r   <= 16'(f_r) * 16'(f_r);
    f3_r   <= 23'(24'(f2_r) * 24'(f_r));
  end

  // Target of the current palette position
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (base_lvl(base_idx(pos_r), 2'(c)))
        LVL_255: tgt[c] = s255_r;
        LVL_235: tgt[c] = s235_r;
        default: tgt[c] = 8'd0;
      endcase
    end
  end

  assign st_cur  = step_rgb(cur_r, tgt);
  assign st_blk  = step_rgb(cur_r, '0);
  assign st_res  = step_rgb(res_r, tgt);
  assign pos_adv = (32'(pos_r) + 32'd1 >= 32'(PALETTE_SIZE)) ? '0 : POS_W'(pos_r + 1'b1);
  assign cand    = n_r | (7'd1 << bit_r);
  assign p3      = 29'(p2_r) * 29'(md_r);

  // Next-state logic of the datapath
  always_comb begin
    tb_nxt      = tb_r;
    bright_nxt  = bright_r;
    speed_nxt   = speed_r;
    settle_nxt  = (settle_r != 2'd0) ? settle_r - 2'd1 : 2'd0;
    cur_nxt     = cur_r;
    res_nxt     = res_r;
    pos_nxt     = pos_r;
    bpn_nxt     = bpn_r;
    stop_nxt    = stop_r;
    it_nxt      = it_r;
    dyn_nxt     = dyn_r;
    run_res_nxt = run_res_r;
    md_nxt      = md_r;
    n_nxt       = n_r;
    bit_nxt     = bit_r;
    step_now    = 1'b0;
    dyn_now     = 1'b0;

    // Take configuration writes; hold input off until derived values settle
    if (cfg_wr) begin
      settle_nxt = 2'd3;
      case (cfg_idx_t'(cfg_index))
        CFG_THROUGH_BLACK: tb_nxt = cfg_wdata[0];
        CFG_BRIGHTNESS:    bright_nxt = cfg_wdata[7:0];
        CFG_FADE_SPEED:    speed_nxt = cfg_wdata[7:0];
        CFG_START_COLOR:   cur_nxt = cfg_wdata;
        default:           tb_nxt = tb_r;
      endcase
    end

    // Open a transaction
    if (cmd.start) begin
      stop_nxt    = in_stop;
      it_nxt      = 2'd0;
      dyn_nxt     = 1'b0;
      run_res_nxt = 1'b0;
      n_nxt       = 7'd0;
      bit_nxt     = 3'd6;
      if (32'(pos_r) >= 32'(PALETTE_SIZE)) pos_nxt = '0;
    end

    // One palette iteration
    if (cmd.iter) begin
      it_nxt = it_r + 2'd1;
      if (!tb_r) begin
        if (cur_r == tgt) begin
          pos_nxt = pos_adv;
        end else begin
          cur_nxt = st_cur.v;
          md_nxt  = st_cur.md;
          step_now = 1'b1;
          dyn_now  = 1'b1;
        end
      end else if (bpn_r && (cur_r != '0)) begin
        cur_nxt = st_blk.v;
        md_nxt  = st_blk.md;
        step_now = 1'b1;
        dyn_now  = 1'b1;
      end else if (res_r != tgt) begin
        res_nxt     = st_res.v;
        run_res_nxt = 1'b1;
        step_now    = 1'b1;
      end else begin
        bpn_nxt = 1'b1;
        res_nxt = '0;
        cur_nxt = tgt;
        pos_nxt = pos_adv;
      end
      dyn_nxt = dyn_now;
    end

    // Cube root search: keep the candidate bit when cand^3 * d fits in F^3
    if (cmd.cr_cmp) begin
      if (p3 <= 29'(f3_r)) n_nxt = cand;
      bit_nxt = bit_r - 3'd1;
    end

    // Abort in the approach phase: restore the resume color
    if (cmd.finish && stop_r && run_res_r) begin
      cur_nxt = res_r;
      bpn_nxt = 1'b0;
    end
  end

  assign sts.iter_done = step_now || (it_r == 2'd2);
  assign sts.need_root = step_now && dyn_now;
  assign sts.bit_last  = (bit_r == 3'd0);
  assign sts.cfg_busy  = (settle_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r     <= 1'b0;
      bright_r <= 8'd255;
      speed_r  <= 8'd255;
      settle_r <= 2'd3;
      cur_r    <= '0;
      res_r    <= '0;
      pos_r    <= '0;
      bpn_r    <= 1'b0;
    end else begin
      tb_r     <= tb_nxt;
      bright_r <= bright_nxt;
      speed_r  <= speed_nxt;
      settle_r <= settle_nxt;
      cur_r    <= cur_nxt;
      res_r    <= res_nxt;
      pos_r    <= pos_nxt;
      bpn_r    <= bpn_nxt;
    end
  end

  // Working registers and cube root products
  always_ff @(posedge clk) begin
    stop_r    <= stop_nxt;
    it_r      <= it_nxt;
    dyn_r     <= dyn_nxt;
    run_res_r <= run_res_nxt;
    md_r      <= md_nxt;
    n_r       <= n_nxt;
    bit_r     <= bit_nxt;
    if (cmd.cr_sq) p1_r <= 14'(cand) * 14'(cand);
    if (cmd.cr_cu) p2_r <= 21'(p1_r) * 21'(cand);
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      slot_r <= 3'(pos_r);
      if (stop_r) begin
        red_r   <= 8'd0;
        green_r <= 8'd0;
        blue_r  <= 8'd0;
        delay_r <= 8'd0;
        intr_r  <= 1'b1;
      end else begin
        red_r   <= run_res_r ? res_r[2] : cur_r[2];
        green_r <= run_res_r ? res_r[1] : cur_r[1];
        blue_r  <= run_res_r ? res_r[0] : cur_r[0];
        delay_r <= dyn_r ? 8'(n_r) : 8'(d5_r);
        intr_r  <= 1'b0;
      end
    end
  end

  assign out_red             = red_r;
  assign out_green           = green_r;
  assign out_blue            = blue_r;
  assign out_frame_delay_ms  = delay_r;
  assign out_was_interrupted = intr_r;
  assign out_palette_slot    = slot_r;

  `RPF_ASSERT(a_pos_range, 32'(pos_r) < 32'(PALETTE_SIZE), "palette position out of range")
  `RPF_ASSERT(a_root_only_dyn, cmd.cr_sq |-> dyn_r, "cube root run on a static step")
  `RPF_ASSERT(a_stop_black, cmd.finish && stop_r |=> (red_r == 8'd0) && (delay_r == 8'd0) && intr_r, "interrupted result not black")

endmodule
